/* hdl/bmf_pkg.sv */
`timescale 1ns / 1ps
// bmf_pkg: shared sizes, register codes, step flags and reciprocal table
// for the box mean filter. No dependencies.
package bmf_pkg;

  localparam int MAX_WIDTH = 2048;
  localparam int MAX_HALF  = 7;

  localparam int PIX_W     = 8;
  localparam int DIM_W     = 12;
  localparam int HALF_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int NUM_LINES = 2 * MAX_HALF;
  localparam int WIN_SIDE  = 2 * MAX_HALF + 1;
  localparam int PIX_MAX   = 2 ** PIX_W - 1;
  // stream position reaches frame size plus the output lag during drains
  localparam int IDX_W     = $clog2((2 ** DIM_W) * MAX_WIDTH + (MAX_HALF + 1) * MAX_WIDTH);
  localparam int CSUM_W    = $clog2(WIN_SIDE * PIX_MAX + 1);
  localparam int WSUM_W    = $clog2(WIN_SIDE * WIN_SIDE * PIX_MAX + 1);
  // shift wide enough that the rounded-up reciprocal gives an exact quotient
  localparam int RECIP_SH  = WSUM_W + $clog2(WIN_SIDE * WIN_SIDE);
  localparam int RECIP_W   = RECIP_SH + 1;

  // ceil(2^RECIP_SH / (2h+1)^2), one entry per radius
  localparam logic [RECIP_W-1:0] RECIP_TAB [MAX_HALF+1] = '{
    RECIP_W'(((2 ** RECIP_SH) + 1 - 1) / 1),
    RECIP_W'(((2 ** RECIP_SH) + 9 - 1) / 9),
    RECIP_W'(((2 ** RECIP_SH) + 25 - 1) / 25),
    RECIP_W'(((2 ** RECIP_SH) + 49 - 1) / 49),
    RECIP_W'(((2 ** RECIP_SH) + 81 - 1) / 81),
    RECIP_W'(((2 ** RECIP_SH) + 121 - 1) / 121),
    RECIP_W'(((2 ** RECIP_SH) + 169 - 1) / 169),
    RECIP_W'(((2 ** RECIP_SH) + 225 - 1) / 225)
  };

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF   = 2'd2;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  localparam logic [DIM_W-1:0]  RST_WIDTH  = 12'd640;
  localparam logic [DIM_W-1:0]  RST_HEIGHT = 12'd480;
  localparam logic [HALF_W-1:0] RST_HALF   = 3'd1;

  typedef struct packed {
    logic valid;
    logic emit;
    logic border;
    logic last;
  } step_t;

endpackage

/* hdl/bmf_ctrl.sv */
`timescale 1ns / 1ps
// bmf_ctrl: configuration registers, stream and output position counters
// and the front stage that feeds the line cells. Uses bmf_pkg.
module bmf_ctrl import bmf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [PIX_W-1:0]     in_tdata,
  input  logic                 in_tuser,
  output step_t                front_step,
  output logic [COL_W-1:0]     front_col,
  output logic [PIX_W-1:0]     front_pix,
  output logic [HALF_W-1:0]    half
);

  localparam int EXT_W = DIM_W + 1;

  function automatic logic [DIM_W-1:0] eff_width(input logic [DIM_W-1:0] w);
    if (w == '0) return DIM_W'(1);
    if (int'(w) > MAX_WIDTH) return DIM_W'(MAX_WIDTH);
    return w;
  endfunction

  function automatic logic [DIM_W-1:0] eff_height(input logic [DIM_W-1:0] ht);
    return (ht == '0) ? DIM_W'(1) : ht;
  endfunction

  function automatic logic [HALF_W-1:0] eff_half(input logic [HALF_W-1:0] h);
    return (int'(h) > MAX_HALF) ? HALF_W'(MAX_HALF) : h;
  endfunction

  logic [DIM_W-1:0]  weff_r, weff_nxt;
  logic [DIM_W-1:0]  heff_r, heff_nxt;
  logic [HALF_W-1:0] half_r, half_nxt;
  logic [IDX_W-1:0]  total_r, total_nxt;
  logic [IDX_W-1:0]  lag_r, lag_nxt;
  logic              cfg_hit;

  logic [COL_W-1:0]  pos_col_r;
  logic [IDX_W-1:0]  pos_idx_r;
  logic [DIM_W-1:0]  out_row_r;
  logic [COL_W-1:0]  out_col_r;
  logic [IDX_W-1:0]  out_idx_r;

  step_t             step_r, step_nxt;
  logic [COL_W-1:0]  col_r;
  logic [PIX_W-1:0]  pix_r;

  logic [IDX_W-1:0]  os_lag;
  logic              drain_ok;
  logic              catch_up;
  logic              in_acc;

  assign cfg_ready = 1'b1;

  always_comb begin
    weff_nxt = weff_r;
    heff_nxt = heff_r;
    half_nxt = half_r;
    cfg_hit  = 1'b0;
    if (cfg_valid) begin
      case (cfg_index)
        REG_WIDTH: begin
          weff_nxt = eff_width(cfg_data);
          cfg_hit  = 1'b1;
        end
        REG_HEIGHT: begin
          heff_nxt = eff_height(cfg_data);
          cfg_hit  = 1'b1;
        end
        REG_HALF: begin
          half_nxt = eff_half(cfg_data[HALF_W-1:0]);
          cfg_hit  = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end
    total_nxt = IDX_W'(weff_nxt) * IDX_W'(heff_nxt);
    lag_nxt   = IDX_W'(half_nxt) * IDX_W'(weff_nxt) + IDX_W'(half_nxt);
  end

  // a drain after a frame smaller than the window first steps the line
  // cells through the gap up to the stream position of the pending output
  assign os_lag    = out_idx_r + lag_r;
  assign drain_ok  = (pos_idx_r >= total_r);
  assign catch_up  = in_tvalid && (in_tuser == ACT_DRAIN) && drain_ok && (pos_idx_r != os_lag);
  assign in_tready = en && !catch_up;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    step_nxt = '0;
    if (en) begin
      if (catch_up) begin
        step_nxt.valid = 1'b1;
      end else if (in_acc && (in_tuser == ACT_PIXEL) && !drain_ok) begin
        step_nxt.valid = 1'b1;
        step_nxt.emit  = (os_lag <= pos_idx_r);
      end else if (in_acc && (in_tuser == ACT_DRAIN) && drain_ok) begin
        step_nxt.valid = 1'b1;
        step_nxt.emit  = 1'b1;
      end
    end
    step_nxt.border = (out_row_r < DIM_W'(half_r))
                   || (EXT_W'(out_row_r) + EXT_W'(half_r) >= EXT_W'(heff_r))
                   || (DIM_W'(out_col_r) < DIM_W'(half_r))
                   || (EXT_W'(out_col_r) + EXT_W'(half_r) >= EXT_W'(weff_r));
    step_nxt.last   = (IDX_W'(out_idx_r + IDX_W'(1)) == total_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weff_r    <= RST_WIDTH;
      heff_r    <= RST_HEIGHT;
      half_r    <= RST_HALF;
      total_r   <= IDX_W'(RST_WIDTH) * IDX_W'(RST_HEIGHT);
      lag_r     <= IDX_W'(RST_HALF) * IDX_W'(RST_WIDTH) + IDX_W'(RST_HALF);
      pos_col_r <= '0;
      pos_idx_r <= '0;
      out_row_r <= '0;
      out_col_r <= '0;
      out_idx_r <= '0;
    end else if (cfg_hit) begin
      weff_r    <= weff_nxt;
      heff_r    <= heff_nxt;
      half_r    <= half_nxt;
      total_r   <= total_nxt;
      lag_r     <= lag_nxt;
      pos_col_r <= '0;
      pos_idx_r <= '0;
      out_row_r <= '0;
      out_col_r <= '0;
      out_idx_r <= '0;
    end else if (step_nxt.valid) begin
      if (step_nxt.emit && step_nxt.last) begin
        pos_col_r <= '0;
        pos_idx_r <= '0;
        out_row_r <= '0;
        out_col_r <= '0;
        out_idx_r <= '0;
      end else begin
        pos_idx_r <= pos_idx_r + IDX_W'(1);
        if (DIM_W'(pos_col_r) == weff_r - DIM_W'(1)) begin
          pos_col_r <= '0;
        end else begin
          pos_col_r <= pos_col_r + COL_W'(1);
        end
        if (step_nxt.emit) begin
          out_idx_r <= out_idx_r + IDX_W'(1);
          if (DIM_W'(out_col_r) == weff_r - DIM_W'(1)) begin
            out_col_r <= '0;
            out_row_r <= out_row_r + DIM_W'(1);
          end else begin
            out_col_r <= out_col_r + COL_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (en) begin
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      col_r <= pos_col_r;
      pix_r <= in_tdata;
    end
  end

  assign front_step = step_r;
  assign front_col  = col_r;
  assign front_pix  = pix_r;
  assign half       = half_r;

  a_out_below_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_idx_r < total_r)
    else $error("output counter reached frame size");

  a_emit_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    step_nxt.emit |-> (pos_idx_r == os_lag))
    else $error("output issued off its stream position");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    drain_ok |-> (pos_idx_r <= os_lag))
    else $error("stream position ran past pending output");

endmodule

/* hdl/bmf_cell.sv */
`timescale 1ns / 1ps
// bmf_cell: one line cell. Holds one image row, hands the older row down
// the chain and, when add_en is set, adds its pixel into the running column sum. Uses bmf_pkg.
module bmf_cell import bmf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              add_en,
  input  logic              ctr_en,
  input  step_t             step_i,
  input  logic [COL_W-1:0]  col_i,
  input  logic [PIX_W-1:0]  pix_i,
  input  logic [CSUM_W-1:0] sum_i,
  input  logic [PIX_W-1:0]  ctr_i,
  output step_t             step_o,
  output logic [COL_W-1:0]  col_o,
  output logic [PIX_W-1:0]  pix_o,
  output logic [CSUM_W-1:0] sum_o,
  output logic [PIX_W-1:0]  ctr_o
);

  logic [PIX_W-1:0]  line_mem [MAX_WIDTH];
  logic [PIX_W-1:0]  rd_r;
  step_t             step_r;
  logic [COL_W-1:0]  col_r;
  logic [CSUM_W-1:0] sum_r;
  logic [PIX_W-1:0]  ctr_r;

  // read-first: the row above leaves as this row goes in
  always_ff @(posedge clk) begin
    if (en && step_i.valid) begin
      rd_r            <= line_mem[col_i];
      line_mem[col_i] <= pix_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (en) begin
      step_r <= step_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      col_r <= col_i;
      sum_r <= sum_i + (add_en ? CSUM_W'(pix_i) : CSUM_W'(0));
      ctr_r <= ctr_en ? pix_i : ctr_i;
    end
  end

  assign step_o = step_r;
  assign col_o  = col_r;
  assign pix_o  = rd_r;
  assign sum_o  = sum_r;
  assign ctr_o  = ctr_r;

endmodule

/* hdl/bmf_win.sv */
`timescale 1ns / 1ps
// bmf_win: horizontal row of column-sum cells, registered adder tree and
// reciprocal divide for the window mean, or the centre pixel on borders. Uses bmf_pkg.
module bmf_win import bmf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic [HALF_W-1:0] half,
  input  step_t             step_i,
  input  logic [CSUM_W-1:0] csum_i,
  input  logic [PIX_W-1:0]  ctr_i,
  output step_t             step_o,
  output logic [PIX_W-1:0]  pix_o
);

  localparam int NUM_GRP = (WIN_SIDE + 3) / 4;
  localparam int GRP_W   = CSUM_W + 2;
  localparam int HIDX_W  = $clog2(WIN_SIDE);
  localparam int PROD_W  = WSUM_W + RECIP_W;

  logic [CSUM_W-1:0] hcol_r [WIN_SIDE];
  logic [PIX_W-1:0]  hctr_r [WIN_SIDE];
  logic [GRP_W-1:0]  part_nxt [NUM_GRP];
  logic [GRP_W-1:0]  part_r [NUM_GRP];
  logic [WSUM_W-1:0] ws_nxt, ws_r;
  logic [PROD_W-1:0] prod_r;
  logic [PIX_W-1:0]  t1_ctr_r, t2_ctr_r, t3_ctr_r;
  step_t             hstep_r, t1_step_r, t2_step_r, t3_step_r;

  always_ff @(posedge clk) begin
    if (en && step_i.valid) begin
      hcol_r[0] <= csum_i;
      hctr_r[0] <= ctr_i;
      for (int j = 1; j < WIN_SIDE; j++) begin
        hcol_r[j] <= hcol_r[j-1];
        hctr_r[j] <= hctr_r[j-1];
      end
    end
  end

  always_comb begin
    for (int g = 0; g < NUM_GRP; g++) begin
      part_nxt[g] = '0;
    end
    for (int j = 0; j < WIN_SIDE; j++) begin
      if (j <= 2 * int'(half)) begin
        part_nxt[j/4] = part_nxt[j/4] + GRP_W'(hcol_r[j]);
      end
    end
  end

  always_comb begin
    ws_nxt = '0;
    for (int g = 0; g < NUM_GRP; g++) begin
      ws_nxt = ws_nxt + WSUM_W'(part_r[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hstep_r   <= '0;
      t1_step_r <= '0;
      t2_step_r <= '0;
      t3_step_r <= '0;
    end else if (en) begin
      hstep_r   <= step_i;
      t1_step_r <= hstep_r;
      t2_step_r <= t1_step_r;
      t3_step_r <= t2_step_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      part_r   <= part_nxt;
      t1_ctr_r <= hctr_r[HIDX_W'(half)];
      ws_r     <= ws_nxt;
      t2_ctr_r <= t1_ctr_r;
      prod_r   <= PROD_W'(ws_r) * PROD_W'(RECIP_TAB[half]);
      t3_ctr_r <= t2_ctr_r;
    end
  end

  assign step_o = t3_step_r;
  assign pix_o  = t3_step_r.border ? t3_ctr_r : prod_r[RECIP_SH +: PIX_W];

endmodule

/* hdl/box_mean_filter.sv */
`timescale 1ns / 1ps
// box_mean_filter: top level. Front control, chain of line cells, window
// stage and output register. Uses bmf_pkg, bmf_ctrl, bmf_cell, bmf_win.
//
// Box mean filter over a (2h+1) x (2h+1) window on a raster stream of 8-bit
// pixels (in_tuser = 0 for a pixel, 1 for a drain). Pixels within h of a
// frame edge pass through unchanged. One item is taken per clock while the
// output side takes results; the result for a window passes through the front
// stage, the chain of 14 line cells, the adder tree, the reciprocal multiplier
// and the output register. A drain that follows a frame smaller than its
// window holds in_tready low while the line cells step up to the pending
// output. The line memories are not cleared after reset. A register write
// restarts the frame; write only while no output is pending.
module box_mean_filter import bmf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [PIX_W-1:0]     in_tdata,   // [7:0] pixel
  input  logic                 in_tuser,   // [0] action
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [PIX_W-1:0]     out_tdata,  // [7:0] out_pixel
  output logic                 out_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  logic              en;
  logic [HALF_W-1:0] half;

  step_t             lane_step [NUM_LINES+1];
  logic [COL_W-1:0]  lane_col  [NUM_LINES+1];
  logic [PIX_W-1:0]  lane_pix  [NUM_LINES+1];
  logic [CSUM_W-1:0] lane_sum  [NUM_LINES+1];
  logic [PIX_W-1:0]  lane_ctr  [NUM_LINES+1];

  logic [CSUM_W-1:0] csum;
  step_t             res_step;
  logic [PIX_W-1:0]  res_pix;

  logic              out_valid_r;
  logic [PIX_W-1:0]  out_pix_r;
  logic              out_last_r;

  // whole pipeline moves unless a result sits untaken
  assign en = !out_valid_r || out_tready;

  bmf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .front_step (lane_step[0]),
    .front_col  (lane_col[0]),
    .front_pix  (lane_pix[0]),
    .half       (half)
  );

  assign lane_sum[0] = '0;
  assign lane_ctr[0] = '0;

  // cell i sees the pixel i rows above the newest one
  for (genvar i = 0; i < NUM_LINES; i++) begin : g_cell
    bmf_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .add_en (i <= 2 * int'(half)),
      .ctr_en (i == int'(half)),
      .step_i (lane_step[i]),
      .col_i  (lane_col[i]),
      .pix_i  (lane_pix[i]),
      .sum_i  (lane_sum[i]),
      .ctr_i  (lane_ctr[i]),
      .step_o (lane_step[i+1]),
      .col_o  (lane_col[i+1]),
      .pix_o  (lane_pix[i+1]),
      .sum_o  (lane_sum[i+1]),
      .ctr_o  (lane_ctr[i+1])
    );
  end

  assign csum = lane_sum[NUM_LINES]
              + ((NUM_LINES <= 2 * int'(half)) ? CSUM_W'(lane_pix[NUM_LINES]) : CSUM_W'(0));

  bmf_win u_win (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .half   (half),
    .step_i (lane_step[NUM_LINES]),
    .csum_i (csum),
    .ctr_i  (lane_ctr[NUM_LINES]),
    .step_o (res_step),
    .pix_o  (res_pix)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= res_step.valid && res_step.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pix_r  <= res_pix;
      out_last_r <= res_step.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pix_r;
  assign out_tlast  = out_last_r;

endmodule

/* tb/tb_checker.sv */
`timescale 1ns / 1ps
// tb_checker: watches the pixel, result and register channels of the box mean
// filter, predicts each filtered pixel and compares. Uses bmf_pkg.
module tb_checker import bmf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [PIX_W-1:0]     in_tdata,
  input  logic                 in_tuser,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [PIX_W-1:0]     out_tdata,
  input  logic                 out_tlast,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  output int                   fails,
  output int                   pending
);

  localparam int RING = (2 * MAX_HALF + 1) * MAX_WIDTH;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             last;
  } filt_t;

  filt_t            filt_q[$];
  logic [PIX_W-1:0] ring_mem [RING];
  logic [DIM_W-1:0] width_reg, height_reg;
  logic [HALF_W-1:0] half_reg;
  int               row_in, col_in, sent_cnt;

  function automatic int eff_w();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return int'(width_reg);
  endfunction

  function automatic int eff_h();
    return (height_reg == 0) ? 1 : int'(height_reg);
  endfunction

  task automatic push_filtered();
    int w, ht, h, tot, q, r, c, sum, side;
    filt_t e;
    w = eff_w(); ht = eff_h(); h = int'(half_reg); tot = w * ht;
    q = sent_cnt; r = q / w; c = q % w;
    if (r < h || r + h >= ht || c < h || c + h >= w) begin
      e.pix = ring_mem[q % RING];
    end else begin
      side = 2 * h + 1;
      sum = 0;
      for (int dr = 0; dr < side; dr++)
        for (int dc = 0; dc < side; dc++)
          sum += ring_mem[((r + dr - h) * w + (c + dc - h)) % RING];
      e.pix = PIX_W'(sum / (side * side));
    end
    sent_cnt = q + 1;
    e.last = (sent_cnt >= tot);
    if (e.last) begin
      row_in = 0; col_in = 0; sent_cnt = 0;
    end
    filt_q.push_back(e);
  endtask

  task automatic take_item(input logic act, input logic [PIX_W-1:0] pix);
    int w, tot, lag, rcv;
    w = eff_w(); tot = w * eff_h();
    lag = int'(half_reg) * w + int'(half_reg);
    rcv = row_in * w + col_in;
    if (act == ACT_PIXEL) begin
      if (rcv >= tot) return;
      ring_mem[rcv % RING] = pix;
      col_in++;
      if (col_in >= w) begin
        col_in = 0; row_in++;
      end
      rcv++;
      if (sent_cnt + lag < rcv) push_filtered();
    end else if (rcv >= tot && sent_cnt < tot) begin
      push_filtered();
    end
  endtask

  always @(posedge clk) begin
    filt_t e;
    if (!rst_n) begin
      width_reg = RST_WIDTH; height_reg = RST_HEIGHT; half_reg = RST_HALF;
      row_in = 0; col_in = 0; sent_cnt = 0;
      filt_q.delete();
      fails = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WIDTH:  width_reg = cfg_data;
          REG_HEIGHT: height_reg = cfg_data;
          REG_HALF:   half_reg = cfg_data[HALF_W-1:0];
          default: ;
        endcase
        if (cfg_index <= REG_HALF) begin
          row_in = 0; col_in = 0; sent_cnt = 0;
        end
      end
      if (in_tvalid && in_tready) take_item(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        if (filt_q.size() == 0) begin
          if (fails < 10) $display("unexpected output pixel %0d last %0b", out_tdata, out_tlast);
          fails++;
        end else begin
          e = filt_q.pop_front();
          if (e.pix !== out_tdata || e.last !== out_tlast) begin
            if (fails < 10)
              $display("mismatch: exp pixel %0d last %0b, got pixel %0d last %0b",
                       e.pix, e.last, out_tdata, out_tlast);
            fails++;
          end
        end
      end
    end
    pending = filt_q.size();
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for box_mean_filter; frames over many sizes
// and radii with random stalls. Uses bmf_pkg, box_mean_filter, tb_checker.
module tb_top;
  import bmf_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0, in_tuser = 1'b0;
  logic [PIX_W-1:0]     in_tdata = '0;
  logic                 in_tready, out_tvalid, out_tlast, cfg_ready;
  logic [PIX_W-1:0]     out_tdata;
  logic                 out_tready = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data = '0;
  int                   fails, pending;

  int  stall_mode = 0;       // 0 none, 1 sender, 2 receiver, 3 both
  bit  hold_req = 0;
  int  item_cnt = 0;
  int  cur_w, cur_h, cur_r;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  box_mean_filter u_top (.*);

  tb_checker u_chk (.*);

  // receiver side; one long hold-off on request so the block backs up
  initial begin
    int hold_cnt;
    bit hold_done;
    hold_cnt = 0; hold_done = 0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1; hold_cnt = 3000;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else if (stall_mode == 2) begin
        out_tready <= ($urandom_range(99) >= 49);
      end else if (stall_mode == 3) begin
        out_tready <= ($urandom_range(99) >= 21);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    #2ms;
    $display("== FAIL ==");
    $finish;
  end

  task automatic send(input logic act, input logic [PIX_W-1:0] pix);
    int idle_pct;
    idle_pct = (stall_mode == 1) ? 49 : (stall_mode == 3) ? 21 : 0;
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= pix;
    do @(posedge clk); while (!in_tready);
    item_cnt++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_frame(input int w, input int ht, input int r);
    write_reg(REG_WIDTH, DIM_W'(w));
    write_reg(REG_HEIGHT, DIM_W'(ht));
    write_reg(REG_HALF, DIM_W'(r));
    cur_w = (w == 0) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
    cur_h = (ht == 0) ? 1 : ht;
    cur_r = r;
  endtask

  // kind: 0 random, 1 all max, 2 all zero, 3 alternating extremes
  task automatic run_frame(input int kind, input bit noisy);
    int tot, n_drain;
    logic [PIX_W-1:0] p;
    tot = cur_w * cur_h;
    n_drain = cur_r * cur_w + cur_r;
    if (n_drain > tot) n_drain = tot;
    for (int i = 0; i < tot; i++) begin
      if (noisy && $urandom_range(19) == 0) send(ACT_DRAIN, PIX_W'($urandom));
      case (kind)
        1: p = '1;
        2: p = '0;
        3: p = i[0] ? '1 : '0;
        default: p = PIX_W'($urandom);
      endcase
      send(ACT_PIXEL, p);
    end
    for (int j = 0; j < n_drain; j++) begin
      // stray pixel while outputs are pending is dropped
      if (noisy && $urandom_range(9) == 0) send(ACT_PIXEL, PIX_W'($urandom));
      send(ACT_DRAIN, PIX_W'($urandom));
    end
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  initial begin
    int ph;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed sizes and extremes
    set_frame(5, 4, 1);    run_frame(1, 0); run_frame(3, 0); settle();
    set_frame(3, 3, 1);    run_frame(2, 0); run_frame(0, 0); settle();
    set_frame(0, 0, 0);    run_frame(1, 0); run_frame(0, 1); settle();
    set_frame(7, 6, 7);    run_frame(0, 0); settle();   // window exceeds frame
    set_frame(16, 15, 7);  run_frame(1, 0); settle();
    write_reg(2'd3, 12'hFFF);                            // unmapped index
    run_frame(0, 0); settle();

    ph = 0;
    while (ph < 8 || item_cnt < 1700) begin
      stall_mode = ph % 4;
      if (ph == 5) begin
        // frame large enough that the held receiver backs up the input
        set_frame(16, 8, 2);
        hold_req = 1;
      end else begin
        set_frame($urandom_range(16, 1), $urandom_range(12, 1), $urandom_range(7));
      end
      repeat ($urandom_range(2, 1))
        run_frame(($urandom_range(9) == 0) ? $urandom_range(3, 1) : 0, 1);
      settle();
      ph++;
    end
    stall_mode = 0;
    settle();
    repeat (60) @(negedge clk);
    if (fails == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/bmf_pkg.sv
hdl/bmf_ctrl.sv
hdl/bmf_cell.sv
hdl/bmf_win.sv
hdl/box_mean_filter.sv
tb/tb_checker.sv
tb/tb_top.sv
